@@ design/mse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mse_pkg;

  localparam int XLEN   = 32;
  localparam int RIDX_W = 5;
  localparam int NREGS  = 32;

  // decoded-instruction queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'd0;
  localparam logic [5:0] OPC_ADDI  = 6'd8;
  localparam logic [5:0] OPC_ADDIU = 6'd9;
  localparam logic [5:0] OPC_ANDI  = 6'd12;
  localparam logic [5:0] OPC_ORI   = 6'd13;
  localparam logic [5:0] OPC_LUI   = 6'd15;

  // R-type funct codes
  localparam logic [5:0] FN_SLL = 6'd0;
  localparam logic [5:0] FN_SRL = 6'd2;
  localparam logic [5:0] FN_SRA = 6'd3;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_NOR = 6'd39;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA,
    ALU_PASSB,
    ALU_BAD
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [RIDX_W-1:0] rs;
    logic [RIDX_W-1:0] rt;
    logic [RIDX_W-1:0] dest;
    logic [RIDX_W-1:0] shamt;
    logic              use_imm;
    logic [XLEN-1:0]   imm;
  } dec_t;

  typedef struct packed {
    logic              unsupported;
    logic [XLEN-1:0]   value;
    logic [RIDX_W-1:0] dest;
    logic              wrote;
  } res_t;

endpackage

`default_nettype wire

@@ design/mse_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mse_decode
  import mse_pkg::*;
(
  input  wire logic [XLEN-1:0] instr_i,
  output dec_t                 dec_o
);

  logic [5:0] opc;
  logic [5:0] fn;

  assign opc = instr_i[31:26];
  assign fn  = instr_i[5:0];

  always_comb begin
    dec_o.rs      = instr_i[25:21];
    dec_o.rt      = instr_i[20:16];
    dec_o.shamt   = instr_i[10:6];
    dec_o.dest    = instr_i[20:16];
    dec_o.use_imm = 1'b1;
    dec_o.imm     = {{16{instr_i[15]}}, instr_i[15:0]};
    dec_o.op      = ALU_BAD;
    unique case (opc)
      OPC_RTYPE: begin
        dec_o.dest    = instr_i[15:11];
        dec_o.use_imm = 1'b0;
        unique case (fn)
          FN_ADD:  dec_o.op = ALU_ADD;
          FN_SUB:  dec_o.op = ALU_SUB;
          FN_AND:  dec_o.op = ALU_AND;
          FN_OR:   dec_o.op = ALU_OR;
          FN_NOR:  dec_o.op = ALU_NOR;
          FN_SLL:  dec_o.op = ALU_SLL;
          FN_SRL:  dec_o.op = ALU_SRL;
          FN_SRA:  dec_o.op = ALU_SRA;
          default: dec_o.op = ALU_BAD;
        endcase
      end
      OPC_ADDI, OPC_ADDIU: begin
        dec_o.op = ALU_ADD;
      end
      OPC_ANDI: begin
        dec_o.op  = ALU_AND;
        dec_o.imm = {16'b0, instr_i[15:0]};
      end
      OPC_ORI: begin
        dec_o.op  = ALU_OR;
        dec_o.imm = {16'b0, instr_i[15:0]};
      end
      OPC_LUI: begin
        dec_o.op  = ALU_PASSB;
        dec_o.imm = {instr_i[15:0], 16'b0};
      end
      default: dec_o.op = ALU_BAD;
    endcase
  end

endmodule

`default_nettype wire

@@ design/mse_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mse_queue
  import mse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  dec_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      nonempty_o,
  output dec_t      head_o
);

  dec_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full_o     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty_o = (cnt_r != '0);
  assign head_o     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/mse_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mse_exec
  import mse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_nonempty_i,
  input  dec_t      q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_res_o
);

  // register file, entry 0 never written so its valid bit stays low
  logic [XLEN-1:0]  rf_r [NREGS];
  logic [NREGS-1:0] rf_vld_r;

  logic            ex_valid_r;
  dec_t            ex_dec_r;
  logic [XLEN-1:0] opa_r;
  logic [XLEN-1:0] opb_r;

  logic            out_valid_r;
  res_t            out_res_r;

  logic            ex_adv;
  logic            issue;
  logic [XLEN-1:0] b_val;
  logic [XLEN-1:0] alu_y;
  res_t            res_nxt;
  logic            wr_en;

  assign ex_adv  = ex_valid_r && (!out_valid_r || out_ready_i);
  assign issue   = q_nonempty_i && (!ex_valid_r || ex_adv);
  assign q_pop_o = issue;

  assign b_val = ex_dec_r.use_imm ? ex_dec_r.imm : opb_r;

  always_comb begin
    unique case (ex_dec_r.op)
      ALU_ADD:   alu_y = opa_r + b_val;
      ALU_SUB:   alu_y = opa_r - b_val;
      ALU_AND:   alu_y = opa_r & b_val;
      ALU_OR:    alu_y = opa_r | b_val;
      ALU_NOR:   alu_y = ~(opa_r | b_val);
      ALU_SLL:   alu_y = b_val << ex_dec_r.shamt;
      ALU_SRL:   alu_y = b_val >> ex_dec_r.shamt;
      ALU_SRA:   alu_y = $unsigned($signed(b_val) >>> ex_dec_r.shamt);
      ALU_PASSB: alu_y = b_val;
      default:   alu_y = '0;
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (ex_dec_r.op == ALU_BAD) begin
      res_nxt.unsupported = 1'b1;
    end else if (ex_dec_r.dest != '0) begin
      res_nxt.wrote = 1'b1;
      res_nxt.dest  = ex_dec_r.dest;
      res_nxt.value = alu_y;
    end
  end

  assign wr_en = ex_adv && res_nxt.wrote;

  // write-back happens on the same edge the next item reads, hence the bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_r[ex_dec_r.dest] <= alu_y;
    end
    if (issue) begin
      ex_dec_r <= q_head_i;
      if (wr_en && ex_dec_r.dest == q_head_i.rs) begin
        opa_r <= alu_y;
      end else if (!rf_vld_r[q_head_i.rs]) begin
        opa_r <= '0;
      end else begin
        opa_r <= rf_r[q_head_i.rs];
      end
      if (wr_en && ex_dec_r.dest == q_head_i.rt) begin
        opb_r <= alu_y;
      end else if (!rf_vld_r[q_head_i.rt]) begin
        opb_r <= '0;
      end else begin
        opb_r <= rf_r[q_head_i.rt];
      end
    end
    if (ex_adv) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r    <= '0;
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        rf_vld_r[ex_dec_r.dest] <= 1'b1;
      end
      if (issue) begin
        ex_valid_r <= 1'b1;
      end else if (ex_adv) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_res_r;

endmodule

`default_nettype wire

@@ design/mips_subset_execute.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Executes one 32-bit MIPS instruction word per request (R-type add, sub, and, or,
// nor, sll, srl, sra; I-type addi, addiu, andi, ori, lui) against a 32 x 32 register
// file with r0 hard-wired to zero, and returns one result per request: wrote, the
// destination register, the value written, and an unsupported flag (set for any
// other opcode or funct, nothing written). Arithmetic wraps, no overflow trap.
// Throughput is one instruction per clock unless out_tready holds the output. The
// request is decoded and enqueued into a 4-entry queue at acceptance, the register
// file is read as the instruction moves from the queue into the execute stage, and
// the execute stage then loads the output register.
// Write-back to an instruction read on the same edge is forwarded, so dependent
// instructions run back to back. Reset clears the register file valid bits at once;
// no clearing pass is needed.
module mips_subset_execute
  import mse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] instr_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [4:0] dest_reg, [36:5] write_value, zero pad
  output logic [1:0]       out_tuser   // [0] wrote, [1] unsupported
);

  dec_t dec;
  dec_t q_head;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic push;
  res_t res;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  mse_decode u_decode (
    .instr_i (in_tdata),
    .dec_o   (dec)
  );

  mse_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (dec),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nonempty_o  (q_nonempty),
    .head_o      (q_head)
  );

  mse_exec u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty_i (q_nonempty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_res_o    (res)
  );

  assign out_tdata = {3'b0, res.value, res.dest};
  assign out_tuser = {res.unsupported, res.wrote};

endmodule

`default_nettype wire

@@ design/mse_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mse_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata == 40'd0)
    else $error("unsupported request reported a write");

  a_write_nonzero_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[4:0] != 5'd0 && out_tdata[39:37] == 3'd0)
    else $error("write reported to r0");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 40'd0)
    else $error("no-write result carries data");

endmodule

bind mips_subset_execute mse_checker u_mse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
